@@ src/tes_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants of the timing event scheduler
// Slot record layout, action and result codes, controller states, the command
// and status bundles between controller and datapath, saturation helpers.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int NUM_EVENTS_DEF = 16;
    localparam int MAX_FIRES_DEF  = 63;

    // signed width of downcount and time since last run
    localparam int DW         = 52;
    // pending time width
    localparam int PW         = 48;
    localparam int SLOT_W     = 4;
    // slot number widened so that it can be compared with the table depth
    localparam int SLOT_EXT_W = 7;
    localparam int DIV_CNT_W  = 6;

    localparam logic [31:0] IDLE_POLL_RST = 32'd100000000;

    typedef enum logic [1:0] {
        ACT_ADVANCE    = 2'd0,
        ACT_ACTIVATE   = 2'd1,
        ACT_DEACTIVATE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_FIRE   = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_ACT_WR,
        S_DEACT,
        S_ERR,
        S_ADD,
        S_SCAN_ADV,
        S_CHECK,
        S_OUTER,
        S_AGE,
        S_SCAN_IN,
        S_INNER,
        S_FIRE_RD,
        S_FIRE_LD,
        S_DIV1,
        S_DIV1_W,
        S_DIV2,
        S_DIV2_W,
        S_FIRE_WB,
        S_END,
        S_SCAN_ST,
        S_STATUS
    } state_t;

    typedef struct packed {
        logic [31:0]          period;
        logic [15:0]          interval;
        logic signed [DW-1:0] downcount;
        logic signed [DW-1:0] since_run;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    typedef struct packed {
        logic  take_in;
        logic  act_wr;
        logic  deact;
        logic  pend_add;
        logic  pend_clr;
        logic  rem_load;
        logic  slice;
        logic  ov_set;
        logic  pend_from_rem;
        logic  sweep_scan;
        logic  sweep_age;
        logic  fire_rd;
        logic  fire_ld;
        logic  div_start;
        logic  div_sel;
        logic  cyc_ld;
        logic  beh_ld;
        logic  fire_wb;
        logic  out_load;
        kind_t out_kind;
    } tes_cmd_t;

    typedef struct packed {
        action_t action;
        logic    slot_ok;
        logic    slot_on;
        logic    found;
        logic    pend_ge_min;
        logic    min_pos;
        logic    rem_zero;
        logic    fires_max;
        logic    sweep_done;
        logic    div_done;
        logic    out_free;
    } tes_sts_t;

    // clamp a signed time to 0..2^32-1
    function automatic logic [31:0] sat_s(input logic signed [DW-1:0] v);
        logic [31:0] r;
        if (v[DW-1]) begin
            r = '0;
        end else if (|v[DW-1:32]) begin
            r = '1;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // clamp an unsigned quotient to 32 bits
    function automatic logic [31:0] sat_u(input logic [DW-1:0] v);
        logic [31:0] r;
        if (|v[DW-1:32]) begin
            r = '1;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/tes_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tes_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_div: radix-2 restoring divider
// Divides an unsigned time by a 32-bit period, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tes_div
    import tes_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [31:0]   divisor,
    output logic [DW-1:0] quotient,
    output logic [31:0]   remainder,
    output logic          busy
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DW-1:0]        dvd_reg;
    logic [DW-1:0]        quo_reg;
    logic [31:0]          rem_reg;
    logic [32:0]          rem_sh;
    logic [32:0]          rem_sub;
    logic                 ge;

    // one trial subtraction per cycle
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DW-1]};
        rem_sub = rem_sh - {1'b0, divisor};
        ge      = rem_sh >= {1'b0, divisor};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DW - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // shift dividend, build quotient and remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            quo_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;

endmodule

@@ src/tes_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_datapath: slot table, time keeping and result register
// Holds the slot RAM, active bits, pending time, the earliest-slot sweep,
// firing arithmetic with the shared divider, and the output item register.
// ----------------------------------------------------------------------------
module tes_datapath
    import tes_pkg::*;
#(
    parameter int NUM_EVENTS = NUM_EVENTS_DEF,
    parameter int MAX_FIRES  = MAX_FIRES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tes_cmd_t          cmd,
    output tes_sts_t          sts,
    input  logic [1:0]        s_action,
    input  logic [SLOT_W-1:0] s_slot,
    input  logic [31:0]       s_period_ns,
    input  logic [15:0]       s_interval,
    input  logic [31:0]       s_start_delay_ns,
    input  logic [31:0]       s_elapsed_ns,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [SLOT_W-1:0] m_fired_slot,
    output logic [31:0]       m_cycles_run,
    output logic [31:0]       m_cycles_behind,
    output logic [31:0]       m_cpu_downcount,
    output logic              m_overflow,
    output logic              m_last
);

    localparam int IW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int CW = $clog2(NUM_EVENTS + 1);
    localparam int FW = $clog2(MAX_FIRES + 1);

    // latched item and configuration
    action_t               action_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [31:0]           period_reg;
    logic [15:0]           interval_reg;
    logic [31:0]           start_reg;
    logic [31:0]           elapsed_reg;
    logic [31:0]           idle_reg;

    // scheduler state
    logic [NUM_EVENTS-1:0] active_reg;
    logic [PW-1:0]         pending_reg;
    logic [PW-1:0]         remain_reg;
    logic [PW-1:0]         t_reg;
    logic [FW-1:0]         fires_reg;
    logic                  ov_reg;

    // sweep
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic                  pend_reg;
    logic [IW-1:0]         ridx_reg;
    logic                  found_reg;
    logic signed [DW-1:0]  min_reg;
    logic [IW-1:0]         min_idx_reg;
    logic                  sweep;
    logic                  sweep_done;
    logic                  issue;

    // firing
    slot_rec_t             rec_reg;
    logic [47:0]           prod_reg;
    logic [31:0]           cyc_reg;
    logic [31:0]           beh_reg;
    logic [31:0]           rrem_reg;

    // output register
    logic                  m_valid_reg;
    kind_t                 kind_reg;
    logic [SLOT_W-1:0]     fslot_reg;
    logic [31:0]           run_reg;
    logic [31:0]           behind_reg;
    logic [31:0]           cpu_reg;
    logic                  mov_reg;
    logic                  last_reg;

    // combinational
    logic [SLOT_EXT_W-1:0] slot_ext;
    logic [SLOT_EXT_W-1:0] min_ext;
    logic [IW-1:0]         slot_addr;
    logic                  slot_ok;
    logic [PW:0]           pend_sum;
    logic [PW-1:0]         pend_sat;
    logic signed [DW-1:0]  pend_s;
    logic signed [DW-1:0]  remain_s;
    logic signed [DW-1:0]  next_dc;
    logic [31:0]           cpu_now;
    logic                  min_pos;
    logic [PW-1:0]         tval;
    slot_rec_t             q;
    slot_rec_t             aged;
    slot_rec_t             fired;
    slot_rec_t             fresh;
    logic signed [DW-1:0]  late;
    logic signed [DW-1:0]  span;
    logic                  span_pos;
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    slot_rec_t             ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [REC_W-1:0]      ram_rdata;
    logic [DW-1:0]         div_dividend;
    logic [DW-1:0]         div_quo;
    logic [31:0]           div_rem;
    logic                  div_busy;
    logic                  out_free;

    // slot decode and time arithmetic
    always_comb begin
        slot_ext  = SLOT_EXT_W'(slot_reg);
        min_ext   = SLOT_EXT_W'(min_idx_reg);
        slot_addr = slot_ext[IW-1:0];
        slot_ok   = slot_ext < SLOT_EXT_W'(NUM_EVENTS);
        pend_sum  = {1'b0, pending_reg} + (PW + 1)'(elapsed_reg);
        pend_sat  = pend_sum[PW] ? '1 : pend_sum[PW-1:0];
        pend_s    = $signed(DW'(pending_reg));
        remain_s  = $signed(DW'(remain_reg));
        next_dc   = found_reg ? min_reg : $signed(DW'(idle_reg));
        cpu_now   = sat_s(next_dc - pend_s);
        min_pos   = !min_reg[DW-1] && (min_reg != '0);
        if (!min_pos) begin
            tval = '0;
        end else if (min_reg > remain_s) begin
            tval = remain_reg;
        end else begin
            tval = min_reg[PW-1:0];
        end
    end

    // record updates for activate, aging and firing
    always_comb begin
        q                = slot_rec_t'(ram_rdata);
        aged             = q;
        aged.downcount   = q.downcount - $signed(DW'(t_reg));
        aged.since_run   = q.since_run + $signed(DW'(t_reg));
        late             = -rec_reg.downcount;
        span             = rec_reg.since_run + rec_reg.downcount;
        span_pos         = !span[DW-1] && (span != '0);
        fired            = rec_reg;
        fired.downcount  = rec_reg.downcount + $signed(DW'(prod_reg));
        fired.since_run  = span_pos ? late + $signed(DW'(rrem_reg)) : rec_reg.since_run;
        fresh.period     = (period_reg == '0) ? 32'd1 : period_reg;
        fresh.interval   = (interval_reg == '0) ? 16'd1 : interval_reg;
        fresh.downcount  = $signed(DW'(start_reg));
        fresh.since_run  = '0;
        div_dividend     = cmd.div_sel ? DW'(late) : (span_pos ? DW'(span) : '0);
    end

    // RAM port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_addr;
        ram_wdata = fresh;
        if (cmd.act_wr && slot_ok) begin
            ram_we = 1'b1;
        end else if (cmd.sweep_age && pend_reg && active_reg[ridx_reg]) begin
            ram_we    = 1'b1;
            ram_waddr = ridx_reg;
            ram_wdata = aged;
        end else if (cmd.fire_wb) begin
            ram_we    = 1'b1;
            ram_waddr = min_idx_reg;
            ram_wdata = fired;
        end
        ram_raddr = cmd.fire_rd ? min_idx_reg : cnt_reg[IW-1:0];
    end

    tes_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_EVENTS),
        .AW    (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tes_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (rec_reg.period),
        .quotient  (div_quo),
        .remainder (div_rem),
        .busy      (div_busy)
    );

    // sweep sequencing: issue one read per cycle, process its data in the next cycle
    always_comb begin
        sweep      = cmd.sweep_scan | cmd.sweep_age;
        sweep_done = (cnt_reg == CW'(NUM_EVENTS)) && !pend_reg;
        issue      = sweep && (cnt_reg != CW'(NUM_EVENTS));
        if (!sweep || sweep_done) begin
            cnt_next = '0;
        end else if (issue) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            pend_reg <= issue && !sweep_done;
        end
        if (issue) begin
            ridx_reg <= cnt_reg[IW-1:0];
        end
    end

    // earliest active slot, lowest index wins ties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.sweep_scan && (cnt_reg == '0)) begin
            found_reg <= 1'b0;
        end else if (cmd.sweep_scan && pend_reg && active_reg[ridx_reg]) begin
            if (!found_reg || (q.downcount < min_reg)) begin
                found_reg <= 1'b1;
            end
        end
        if (cmd.sweep_scan && pend_reg && active_reg[ridx_reg] &&
            (!found_reg || (q.downcount < min_reg))) begin
            min_reg     <= q.downcount;
            min_idx_reg <= ridx_reg;
        end
    end

    // latch item fields on accept
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            action_reg   <= action_t'(s_action);
            slot_reg     <= s_slot;
            period_reg   <= s_period_ns;
            interval_reg <= s_interval;
            start_reg    <= s_start_delay_ns;
            elapsed_reg  <= s_elapsed_ns;
        end
    end

    // configuration, active bits, pending time and firing count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg    <= IDLE_POLL_RST;
            active_reg  <= '0;
            pending_reg <= '0;
            remain_reg  <= '0;
            fires_reg   <= '0;
            ov_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                idle_reg <= cfg_wdata;
            end
            if (cmd.act_wr && slot_ok) begin
                active_reg[slot_addr] <= 1'b1;
            end else if (cmd.deact) begin
                active_reg[slot_addr] <= 1'b0;
            end
            if (cmd.take_in) begin
                ov_reg    <= 1'b0;
                fires_reg <= '0;
            end else if (cmd.ov_set) begin
                ov_reg <= 1'b1;
            end else if (cmd.fire_wb) begin
                fires_reg <= fires_reg + 1'b1;
            end
            if (cmd.pend_add) begin
                pending_reg <= pend_sat;
            end else if (cmd.pend_clr) begin
                pending_reg <= '0;
            end else if (cmd.pend_from_rem) begin
                pending_reg <= remain_reg;
            end
            if (cmd.rem_load) begin
                remain_reg <= pending_reg;
            end else if (cmd.slice) begin
                remain_reg <= remain_reg - tval;
            end
        end
    end

    // slice length and firing arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.slice) begin
            t_reg <= tval;
        end
        if (cmd.fire_ld) begin
            rec_reg <= q;
        end
        prod_reg <= rec_reg.period * rec_reg.interval;
        if (cmd.cyc_ld) begin
            cyc_reg  <= sat_u(div_quo);
            rrem_reg <= div_rem;
        end
        if (cmd.beh_ld) begin
            beh_reg <= sat_u(div_quo);
        end
    end

    // output item register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            kind_reg <= cmd.out_kind;
            case (cmd.out_kind)
                KIND_FIRE: begin
                    fslot_reg  <= min_ext[SLOT_W-1:0];
                    run_reg    <= cyc_reg;
                    behind_reg <= beh_reg;
                    cpu_reg    <= '0;
                    mov_reg    <= 1'b0;
                    last_reg   <= 1'b0;
                end
                KIND_STATUS: begin
                    fslot_reg  <= (action_reg == ACT_ADVANCE) ? '0 : slot_reg;
                    run_reg    <= '0;
                    behind_reg <= '0;
                    cpu_reg    <= cpu_now;
                    mov_reg    <= ov_reg;
                    last_reg   <= 1'b1;
                end
                default: begin
                    fslot_reg  <= slot_reg;
                    run_reg    <= '0;
                    behind_reg <= '0;
                    cpu_reg    <= '0;
                    mov_reg    <= 1'b0;
                    last_reg   <= 1'b1;
                end
            endcase
        end
    end

    // status to controller
    always_comb begin
        sts.action      = action_reg;
        sts.slot_ok     = slot_ok;
        sts.slot_on     = active_reg[slot_addr];
        sts.found       = found_reg;
        sts.pend_ge_min = pend_s >= min_reg;
        sts.min_pos     = min_pos;
        sts.rem_zero    = remain_reg == '0;
        sts.fires_max   = fires_reg >= FW'(MAX_FIRES);
        sts.sweep_done  = sweep_done;
        sts.div_done    = !div_busy;
        sts.out_free    = out_free;
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_fired_slot    = fslot_reg;
    assign m_cycles_run    = run_reg;
    assign m_cycles_behind = behind_reg;
    assign m_cpu_downcount = cpu_reg;
    assign m_overflow      = mov_reg;
    assign m_last          = last_reg;

endmodule

@@ src/tes_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_ctrl: scheduler controller
// Sequences decode, slot updates, time slices, firings and the result items.
// ----------------------------------------------------------------------------
module tes_ctrl
    import tes_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tes_sts_t sts,
    output tes_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.action)
                    ACT_ADVANCE:    state_next = S_ADD;
                    ACT_ACTIVATE:   state_next = sts.slot_ok ? S_ACT_WR : S_SCAN_ST;
                    ACT_DEACTIVATE: state_next = (sts.slot_ok && sts.slot_on) ? S_DEACT : S_ERR;
                    default:        state_next = S_IDLE;
                endcase
            end
            S_ACT_WR:   state_next = S_SCAN_ST;
            S_DEACT:    state_next = S_SCAN_ST;
            S_ERR: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_ADD:      state_next = S_SCAN_ADV;
            S_SCAN_ADV: begin
                if (sts.sweep_done) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!sts.found || !sts.pend_ge_min) begin
                    state_next = S_STATUS;
                end else begin
                    state_next = S_OUTER;
                end
            end
            S_OUTER: begin
                if (sts.rem_zero || !sts.found) begin
                    state_next = S_END;
                end else begin
                    state_next = S_AGE;
                end
            end
            S_AGE: begin
                if (sts.sweep_done) begin
                    state_next = S_SCAN_IN;
                end
            end
            S_SCAN_IN: begin
                if (sts.sweep_done) begin
                    state_next = S_INNER;
                end
            end
            S_INNER: begin
                if (!sts.found || sts.min_pos) begin
                    state_next = S_OUTER;
                end else if (sts.fires_max) begin
                    state_next = S_END;
                end else begin
                    state_next = S_FIRE_RD;
                end
            end
            S_FIRE_RD:  state_next = S_FIRE_LD;
            S_FIRE_LD:  state_next = S_DIV1;
            S_DIV1:     state_next = S_DIV1_W;
            S_DIV1_W: begin
                if (sts.div_done) begin
                    state_next = S_DIV2;
                end
            end
            S_DIV2:     state_next = S_DIV2_W;
            S_DIV2_W: begin
                if (sts.div_done) begin
                    state_next = S_FIRE_WB;
                end
            end
            S_FIRE_WB: begin
                if (sts.out_free) begin
                    state_next = S_SCAN_IN;
                end
            end
            S_END:      state_next = S_STATUS;
            S_SCAN_ST: begin
                if (sts.sweep_done) begin
                    state_next = S_STATUS;
                end
            end
            S_STATUS: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd          = '0;
        cmd.out_kind = KIND_STATUS;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.take_in = s_valid;
            end
            S_ACT_WR:   cmd.act_wr = 1'b1;
            S_DEACT:    cmd.deact = 1'b1;
            S_ERR: begin
                cmd.out_load = sts.out_free;
                cmd.out_kind = KIND_ERROR;
            end
            S_ADD:      cmd.pend_add = 1'b1;
            S_SCAN_ADV: cmd.sweep_scan = 1'b1;
            S_CHECK: begin
                cmd.pend_clr = !sts.found;
                cmd.rem_load = sts.found && sts.pend_ge_min;
            end
            S_OUTER:    cmd.slice = !sts.rem_zero && sts.found;
            S_AGE:      cmd.sweep_age = 1'b1;
            S_SCAN_IN:  cmd.sweep_scan = 1'b1;
            S_INNER:    cmd.ov_set = sts.found && !sts.min_pos && sts.fires_max;
            S_FIRE_RD:  cmd.fire_rd = 1'b1;
            S_FIRE_LD:  cmd.fire_ld = 1'b1;
            S_DIV1:     cmd.div_start = 1'b1;
            S_DIV1_W:   cmd.cyc_ld = sts.div_done;
            S_DIV2: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
            end
            S_DIV2_W:   cmd.beh_ld = sts.div_done;
            S_FIRE_WB: begin
                cmd.fire_wb  = sts.out_free;
                cmd.out_load = sts.out_free;
                cmd.out_kind = KIND_FIRE;
            end
            S_END:      cmd.pend_from_rem = 1'b1;
            S_SCAN_ST:  cmd.sweep_scan = 1'b1;
            S_STATUS:   cmd.out_load = sts.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

@@ src/timing_event_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_event_scheduler: periodic timing event scheduler
// Table of periodic events driven by advance, activate and deactivate items.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Activate and a successful deactivate
// run one sweep of the slot RAM to find the earliest event for the status
// item. An advance runs one sweep when nothing fires; each time slice adds
// two RAM sweeps (aging, then search), and each firing adds two divisions in
// the shared bit-serial divider and the search that follows. Closing a sliced
// advance moves the unspent time back to the pending time. Results leave
// through a one-item output register; a stalled output holds the controller.
// Slot records need no clearing after reset: the active bits gate every read.
// ----------------------------------------------------------------------------
module timing_event_scheduler
    import tes_pkg::*;
#(
    parameter int NUM_EVENTS = NUM_EVENTS_DEF,
    parameter int MAX_FIRES  = MAX_FIRES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [SLOT_W-1:0] s_slot,
    input  logic [31:0]       s_period_ns,
    input  logic [15:0]       s_interval,
    input  logic [31:0]       s_start_delay_ns,
    input  logic [31:0]       s_elapsed_ns,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_wdata,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [SLOT_W-1:0] m_fired_slot,
    output logic [31:0]       m_cycles_run,
    output logic [31:0]       m_cycles_behind,
    output logic [31:0]       m_cpu_downcount,
    output logic              m_overflow,
    output logic              m_last
);

    tes_cmd_t cmd;
    tes_sts_t sts;

    assign cfg_ready = 1'b1;

    tes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tes_datapath #(
        .NUM_EVENTS (NUM_EVENTS),
        .MAX_FIRES  (MAX_FIRES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_action         (s_action),
        .s_slot           (s_slot),
        .s_period_ns      (s_period_ns),
        .s_interval       (s_interval),
        .s_start_delay_ns (s_start_delay_ns),
        .s_elapsed_ns     (s_elapsed_ns),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_wdata        (cfg_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_fired_slot     (m_fired_slot),
        .m_cycles_run     (m_cycles_run),
        .m_cycles_behind  (m_cycles_behind),
        .m_cpu_downcount  (m_cpu_downcount),
        .m_overflow       (m_overflow),
        .m_last           (m_last)
    );

    // one item in flight: accept closes the input until the item is done
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // firings never close an item
    a_fire_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_FIRE)) |-> !m_last)
        else $error("fired item marked last");

    // status and error items close an item
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind != KIND_FIRE)) |-> m_last)
        else $error("status or error item not marked last");

    // firings carry no downcount and no overflow
    a_fire_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_FIRE)) |-> ((m_cpu_downcount == '0) && !m_overflow))
        else $error("fired item carries status fields");

endmodule

@@ verif/timing_event_scheduler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_event_scheduler_tb: self-checking testbench of the event scheduler
// Drives activate, deactivate, advance and unused-action items through the input channel and
// keeps its own copy of the event table. For each accepted item it computes
// the firings and the status the block must return, and checks every result
// field by field, in order. Idle and stall patterns on both channels vary by
// phase, and the idle poll register is rewritten between phases.
// ----------------------------------------------------------------------------
module timing_event_scheduler_tb
    import tes_pkg::*;
();

    localparam int          SLOTS      = 16;
    localparam int          FIRE_LIMIT = 63;
    localparam longint      PEND_SAT   = 64'hFFFF_FFFF_FFFF;
    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam int          CYCLE_CAP  = 30000000;
    localparam int          DRAIN_WAIT = 200;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  fslot;
        logic [31:0] run;
        logic [31:0] behind;
        logic [31:0] dcount;
        logic        ovf;
        logic        lst;
    } sched_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [3:0]  s_slot;
    logic [31:0] s_period_ns;
    logic [15:0] s_interval;
    logic [31:0] s_start_delay_ns;
    logic [31:0] s_elapsed_ns;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_wdata;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [3:0]  m_fired_slot;
    logic [31:0] m_cycles_run;
    logic [31:0] m_cycles_behind;
    logic [31:0] m_cpu_downcount;
    logic        m_overflow;
    logic        m_last;

    // event table shadow
    logic        ev_on       [SLOTS];
    longint      ev_period   [SLOTS];
    longint      ev_interval [SLOTS];
    longint      ev_down     [SLOTS];
    longint      ev_since    [SLOTS];
    longint      pend_ns;
    logic [31:0] idle_poll;

    sched_res_t  due_q[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          cycle_count;

    timing_event_scheduler u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_slot           (s_slot),
        .s_period_ns      (s_period_ns),
        .s_interval       (s_interval),
        .s_start_delay_ns (s_start_delay_ns),
        .s_elapsed_ns     (s_elapsed_ns),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_wdata        (cfg_wdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_fired_slot     (m_fired_slot),
        .m_cycles_run     (m_cycles_run),
        .m_cycles_behind  (m_cycles_behind),
        .m_cpu_downcount  (m_cpu_downcount),
        .m_overflow       (m_overflow),
        .m_last           (m_last)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Scheduler prediction
    // ------------------------------------------------------------------------
    function automatic logic [31:0] clamp32(input longint v);
        if (v < 0) return 32'd0;
        if (v > 64'sh0_FFFF_FFFF) return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    // lowest slot with the smallest downcount, -1 when the table is empty
    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (ev_on[i] && (best < 0 || ev_down[i] < ev_down[best])) best = i;
        end
        return best;
    endfunction

    function automatic logic [31:0] next_downcount();
        int     e;
        longint nxt;
        e = earliest_slot();
        nxt = (e < 0) ? longint'(idle_poll) : ev_down[e];
        return clamp32(nxt - pend_ns);
    endfunction

    function automatic void push_result(input logic [1:0] k, input int sl,
                                        input logic [31:0] run, input logic [31:0] beh,
                                        input logic [31:0] dc, input logic ov,
                                        input logic lst);
        sched_res_t r;
        r.kind = k; r.fslot = sl[3:0]; r.run = run; r.behind = beh;
        r.dcount = dc; r.ovf = ov; r.lst = lst;
        due_q.insert(due_q.size(), r);
    endfunction

    // spend pending time in slices, firing due events
    function automatic void advance_time(input logic [31:0] elapsed);
        int     e;
        int     f;
        int     fires;
        logic   ovf;
        longint remaining;
        longint t;
        longint per;
        longint late;
        longint span;
        longint cyc;
        pend_ns += longint'(elapsed);
        if (pend_ns > PEND_SAT) pend_ns = PEND_SAT;
        ovf = 1'b0;
        fires = 0;
        e = earliest_slot();
        if (e < 0) begin
            pend_ns = 0;
        end else if (pend_ns >= ev_down[e]) begin
            remaining = pend_ns;
            while (remaining > 0 && !ovf) begin
                e = earliest_slot();
                if (e < 0) break;
                t = ev_down[e];
                if (t > remaining) t = remaining;
                if (t < 0) t = 0;
                remaining -= t;
                // age every active event
                for (int i = 0; i < SLOTS; i++) begin
                    if (ev_on[i]) begin
                        ev_down[i] -= t;
                        ev_since[i] += t;
                    end
                end
                // fire due events, earliest and lowest slot first
                forever begin
                    f = earliest_slot();
                    if (f < 0 || ev_down[f] > 0) break;
                    if (fires >= FIRE_LIMIT) begin
                        ovf = 1'b1;
                        break;
                    end
                    per = ev_period[f];
                    late = -ev_down[f];
                    span = ev_since[f] - late;
                    cyc = (span > 0) ? span / per : 0;
                    ev_down[f] += per * ev_interval[f];
                    ev_since[f] -= cyc * per;
                    push_result(KIND_FIRE, f, clamp32(cyc), clamp32(late / per),
                                32'd0, 1'b0, 1'b0);
                    fires++;
                end
            end
            pend_ns = remaining;
        end
        push_result(KIND_STATUS, 0, 32'd0, 32'd0, next_downcount(), ovf, 1'b1);
    endfunction

    function automatic void predict_item(input logic [1:0] act, input logic [3:0] sl,
                                         input logic [31:0] per, input logic [15:0] itv,
                                         input logic [31:0] dly, input logic [31:0] elp);
        case (act)
            ACT_ACTIVATE: begin
                ev_period[sl]   = (per == 0) ? 1 : longint'(per);
                ev_interval[sl] = (itv == 0) ? 1 : longint'(itv);
                ev_down[sl]     = longint'(dly);
                ev_since[sl]    = 0;
                ev_on[sl]       = 1'b1;
                push_result(KIND_STATUS, sl, 32'd0, 32'd0, next_downcount(), 1'b0, 1'b1);
            end
            ACT_DEACTIVATE: begin
                if (!ev_on[sl]) begin
                    push_result(KIND_ERROR, sl, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
                end else begin
                    ev_on[sl] = 1'b0;
                    push_result(KIND_STATUS, sl, 32'd0, 32'd0, next_downcount(),
                                1'b0, 1'b1);
                end
            end
            ACT_ADVANCE: advance_time(elp);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input and configuration drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] act, input logic [3:0] sl,
                             input logic [31:0] per, input logic [15:0] itv,
                             input logic [31:0] dly, input logic [31:0] elp);
        // random idle gap before the item
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_action = act; s_slot = sl; s_period_ns = per;
        s_interval = itv; s_start_delay_ns = dly; s_elapsed_ns = elp;
        do @(posedge aclk); while (!s_ready);
        predict_item(act, sl, per, itv, dly, elp);
    endtask

    task automatic send_advance(input logic [31:0] elp);
        send_item(ACT_ADVANCE, 4'd0, 32'd0, 16'd0, 32'd0, elp);
    endtask

    task automatic send_activate(input logic [3:0] sl, input logic [31:0] per,
                                 input logic [15:0] itv, input logic [31:0] dly);
        send_item(ACT_ACTIVATE, sl, per, itv, dly, $urandom);
    endtask

    task automatic send_deactivate(input logic [3:0] sl);
        send_item(ACT_DEACTIVATE, sl, $urandom, 16'($urandom), $urandom, $urandom);
    endtask

    // wait until every expected result is back, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (due_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_idle_poll(input logic [31:0] v);
        drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_wdata = v;
        do @(posedge aclk); while (!cfg_ready);
        idle_poll = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // drop every active event and clear the pending time
    task automatic clear_table();
        for (int i = 0; i < SLOTS; i++) begin
            if (ev_on[i]) send_deactivate(i[3:0]);
        end
        send_advance(32'd0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall and result check
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        sched_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result kind %0d slot %0d",
                                               m_kind, m_fired_slot);
            end else begin
                want = due_q.pop_front();
                if (m_kind !== want.kind || m_fired_slot !== want.fslot ||
                    m_cycles_run !== want.run || m_cycles_behind !== want.behind ||
                    m_cpu_downcount !== want.dcount || m_overflow !== want.ovf ||
                    m_last !== want.lst) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp k%0d s%0d run %0d beh %0d dc %0d ov %0d l %0d",
                                 want.kind, want.fslot, want.run, want.behind,
                                 want.dcount, want.ovf, want.lst);
                        $display("         got k%0d s%0d run %0d beh %0d dc %0d ov %0d l %0d",
                                 m_kind, m_fired_slot, m_cycles_run, m_cycles_behind,
                                 m_cpu_downcount, m_overflow, m_last);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("[timing_event_scheduler] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_advance(32'd0);
        send_advance(32'hFFFF_FFFF);
        send_deactivate(4'd5);
        send_item(ACT_UNUSED, 4'd9, 32'd1, 16'd1, 32'd1, 32'd1);
        // zero period and interval fall back to one; zero pending waits
        send_activate(4'd0, 32'd0, 16'd0, 32'd0);
        send_advance(32'd0);
        send_advance(32'd10);
        send_deactivate(4'd0);
        send_activate(4'd15, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        // equal downcounts: slot 3 before slot 4, then re-arm slot 3
        send_activate(4'd3, 32'd100, 16'd2, 32'd50);
        send_activate(4'd4, 32'd100, 16'd2, 32'd50);
        send_advance(32'd450);
        send_activate(4'd3, 32'd7, 16'd1, 32'd20);
        send_advance(32'd90);
        // firing limit with large pending time
        send_advance(32'hFFFF_FFFF);
        send_advance(32'hFFFF_FFFF);
        send_deactivate(4'd3);
        send_deactivate(4'd4);
        send_deactivate(4'd15);
        send_deactivate(4'd15);
        send_advance(32'd0);
    endtask

    task automatic test_idle_poll();
        write_idle_poll(32'd1);
        send_advance(32'd5);
        send_activate(4'd2, 32'd10, 16'd1, 32'd3);
        send_deactivate(4'd2);
        write_idle_poll(32'hFFFF_FFFF);
        send_advance(32'd0);
        send_activate(4'd8, 32'd10, 16'd1, 32'd3);
        send_deactivate(4'd8);
        write_idle_poll(32'h5A5A_A5A5);
        send_advance(32'd1);
    endtask

    // hold the receiver while a burst of firings backs up into the input
    task automatic test_backpressure();
        drain();
        hold_cycles = 600;
        send_activate(4'd6, 32'd10, 16'd1, 32'd0);
        send_activate(4'd7, 32'd13, 16'd1, 32'd5);
        for (int i = 0; i < 6; i++) send_advance(32'd40);
        clear_table();
    endtask

    task automatic test_random(input int count);
        int          r;
        logic [3:0]  sl;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            sl = 4'($urandom_range(0, SLOTS - 1));
            if (r < 3) begin
                send_item(ACT_UNUSED, sl, $urandom, 16'($urandom), $urandom, $urandom);
                n--;
            end else if (r < 6) begin
                send_activate(sl, $urandom, 16'($urandom), $urandom);
            end else if (r < 32) begin
                send_activate(sl, $urandom_range(50, 2000), 16'($urandom_range(1, 4)),
                              $urandom_range(0, 3000));
            end else if (r < 47) begin
                send_deactivate(sl);
            end else if (r < 49) begin
                // huge step: fire up to the limit, then start clean
                send_advance($urandom);
                clear_table();
            end else begin
                send_advance($urandom_range(0, 1500));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0; s_action = ACT_ADVANCE; s_slot = '0; s_period_ns = '0;
        s_interval = '0; s_start_delay_ns = '0; s_elapsed_ns = '0;
        cfg_valid = 1'b0; cfg_wdata = '0;
        m_ready = 1'b0;
        hold_cycles = 0; cycle_count = 0; mismatches = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        idle_poll = IDLE_POLL_RST;
        pend_ns = 0;
        for (int i = 0; i < SLOTS; i++) begin
            ev_on[i] = 1'b0; ev_period[i] = 1; ev_interval[i] = 1;
            ev_down[i] = 0; ev_since[i] = 0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_idle_poll();
        test_backpressure();

        write_idle_poll(32'd12345);
        test_random(76);
        send_idle_pct = 58;
        write_idle_poll(32'd1);
        test_random(76);
        send_idle_pct = 0;
        recv_stall_pct = 58;
        write_idle_poll(32'hFFFF_FFFF);
        test_random(76);
        send_idle_pct = 35;
        recv_stall_pct = 35;
        write_idle_poll($urandom);
        test_random(76);

        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && due_q.size() == 0) begin
            $display("[timing_event_scheduler] OK");
        end else begin
            $display("[timing_event_scheduler] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/tes_pkg.sv
src/tes_ram.sv
src/tes_div.sv
src/tes_datapath.sv
src/tes_ctrl.sv
src/timing_event_scheduler.sv
verif/timing_event_scheduler_tb.sv
